### rtl/core/text_console_writer_unit_defines.svh
// Assertion macros for the text console writer checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package tcw_pkg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCROLL,
        ST_DONE
    } t_state;

    // What a sweep over the whole store does.
    typedef enum logic [1:0] {
        SW_INIT,
        SW_FILL,
        SW_SCROLL
    } t_sweep;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [3:0] RESET_FG = 4'hF;
    localparam logic [3:0] RESET_BG = 4'h0;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam logic [15:0] RESET_CELL = {RESET_BG, RESET_FG, CH_SPACE};

    typedef struct packed {
        logic   exec;
        logic   sweep;
        t_sweep mode;
        logic   load;
    } t_dp_cmd;

    typedef struct packed {
        logic will_scroll;
        logic is_clear;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [15:0] make_cell(input logic [3:0] bg, input logic [3:0] fg,
                                              input logic [7:0] ch);
        return {bg, fg, ch};
    endfunction

endpackage

### rtl/core/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives tcw_dp through t_dp_cmd and reads t_dp_sts.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tcw_pkg::t_dp_sts i_sts,
    output tcw_pkg::t_dp_cmd o_cmd
);
    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_sts.is_clear) begin
                        n_state = ST_CLEAR;
                    end else if (i_sts.will_scroll) begin
                        n_state = ST_SCROLL;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_CLEAR, ST_SCROLL: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_cmd.exec  = 1'b0;
        o_cmd.sweep = 1'b0;
        o_cmd.mode  = SW_FILL;
        o_cmd.load  = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep = 1'b1;
                o_cmd.mode  = SW_INIT;
            end
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.exec = i_valid;
            end
            ST_CLEAR: begin
                o_cmd.sweep = 1'b1;
                o_cmd.mode  = SW_FILL;
            end
            ST_SCROLL: begin
                o_cmd.sweep = 1'b1;
                o_cmd.mode  = SW_SCROLL;
            end
            ST_DONE: begin
                o_cmd.load = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/tcw_dp.sv
// Datapath of the text console writer: cell store, cursor, colour registers
// and output register. Depends on tcw_pkg; commanded by tcw_ctrl.
`timescale 1ns / 1ps

module tcw_dp #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [3:0]       i_cfg_data,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_char_code,
    input  logic [10:0]      i_read_index,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [4:0]       o_cursor_row,
    output logic [6:0]       o_cursor_col,
    output logic [10:0]      o_cursor_pos,
    output logic [15:0]      o_read_cell,
    output logic             o_scrolled,
    input  tcw_pkg::t_dp_cmd i_cmd,
    output tcw_pkg::t_dp_sts o_sts
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(CELLS);
    localparam int AW1   = AW + 1;
    localparam int IW    = (AW > 11) ? AW : 11;

    localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);
    localparam logic [AW-1:0] ADDR_LAST   = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM_BASE = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);

    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rdata;

    logic [3:0]    r_fg;
    logic [3:0]    r_bg;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_pos;
    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic [AW-1:0] n_pos;

    logic [AW-1:0] r_addr;
    logic          r_cp_valid;
    logic          r_cp_blank;
    logic [AW-1:0] r_cp_addr;

    logic          r_rd_ok;
    logic          r_scrolled;

    logic          r_ov;
    logic [4:0]    r_o_row;
    logic [6:0]    r_o_col;
    logic [10:0]   r_o_pos;
    logic [15:0]   r_o_cell;
    logic          r_o_scr;

    logic [15:0]   blank;
    logic          ex_wr;
    logic [AW-1:0] ex_addr;
    logic [15:0]   ex_data;
    logic          ex_scroll;
    logic          rd_ok;
    logic          sweep_last;
    logic          src_blank;
    logic [AW-1:0] src_addr;
    logic          out_free;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic          re;
    logic [AW-1:0] raddr;

    assign blank      = make_cell(r_bg, r_fg, CH_SPACE);
    assign sweep_last = (r_addr == ADDR_LAST);
    assign src_blank  = (r_addr >= BOTTOM_BASE);
    assign src_addr   = AW'(AW1'(r_addr) + AW1'(COLUMNS));
    assign rd_ok      = (i_kind == KIND_READ) && (IW'(i_read_index) < IW'(CELLS));
    assign out_free   = !r_ov || i_ready;

    // Cursor update and cell write for an accepted item.
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_pos     = r_pos;
        ex_wr     = 1'b0;
        ex_addr   = r_pos;
        ex_data   = make_cell(r_bg, r_fg, i_char_code);
        ex_scroll = 1'b0;
        case (i_kind)
            KIND_PUT: begin
                if (i_char_code == CH_NEWLINE) begin
                    n_col = '0;
                    if (r_row == ROW_LAST) begin
                        ex_scroll = 1'b1;
                        n_pos     = BOTTOM_BASE;
                    end else begin
                        n_row = r_row + RW'(1);
                        n_pos = r_pos - AW'(r_col) + ROW_STEP;
                    end
                end else if (i_char_code == CH_BACKSPACE) begin
                    ex_wr   = 1'b1;
                    ex_data = blank;
                    if (r_col != '0) begin
                        n_col = r_col - CW'(1);
                        n_pos = r_pos - AW'(1);
                    end else if (r_row != '0) begin
                        n_row = r_row - RW'(1);
                        n_col = COL_LAST;
                        n_pos = r_pos - AW'(1);
                    end
                    ex_addr = n_pos;
                end else begin
                    ex_wr = 1'b1;
                    if (r_col == COL_LAST) begin
                        n_col = '0;
                        if (r_row == ROW_LAST) begin
                            ex_scroll = 1'b1;
                            n_pos     = BOTTOM_BASE;
                        end else begin
                            n_row = r_row + RW'(1);
                            n_pos = r_pos + AW'(1);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                        n_pos = r_pos + AW'(1);
                    end
                end
            end
            KIND_CLEAR: begin
                n_row = '0;
                n_col = '0;
                n_pos = '0;
            end
            default: ;
        endcase
    end

    // One write port: delayed scroll copy, then fill sweeps, then item writes.
    always_comb begin
        we    = 1'b0;
        waddr = ex_addr;
        wdata = ex_data;
        if (r_cp_valid) begin
            we    = 1'b1;
            waddr = r_cp_addr;
            wdata = r_cp_blank ? blank : r_rdata;
        end else if (i_cmd.sweep && (i_cmd.mode != SW_SCROLL)) begin
            we    = 1'b1;
            waddr = r_addr;
            wdata = (i_cmd.mode == SW_INIT) ? RESET_CELL : blank;
        end else if (i_cmd.exec && ex_wr) begin
            we = 1'b1;
        end
    end

    always_comb begin
        re    = 1'b0;
        raddr = src_addr;
        if (i_cmd.exec) begin
            re    = rd_ok;
            raddr = AW'(i_read_index);
        end else if (i_cmd.sweep && (i_cmd.mode == SW_SCROLL)) begin
            re = !src_blank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // Scroll copy writes in the cycle after its read; the bottom row gets blanks.
    always_ff @(posedge i_clk) begin
        r_cp_blank <= src_blank;
        r_cp_addr  <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_cp_valid <= 1'b0;
            r_fg       <= RESET_FG;
            r_bg       <= RESET_BG;
            r_row      <= '0;
            r_col      <= '0;
            r_pos      <= '0;
            r_rd_ok    <= 1'b0;
            r_scrolled <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_cp_valid <= i_cmd.sweep && (i_cmd.mode == SW_SCROLL);
            if (i_cmd.sweep) begin
                r_addr <= sweep_last ? '0 : r_addr + AW'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FG:  r_fg <= i_cfg_data;
                    CFG_BG:  r_bg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_row      <= n_row;
                r_col      <= n_col;
                r_pos      <= n_pos;
                r_rd_ok    <= rd_ok;
                r_scrolled <= ex_scroll;
            end
            if (i_cmd.load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_row  <= 5'(r_row);
            r_o_col  <= 7'(r_col);
            r_o_pos  <= 11'(r_pos);
            r_o_cell <= r_rd_ok ? r_rdata : 16'h0000;
            r_o_scr  <= r_scrolled;
        end
    end

    assign o_valid      = r_ov;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_cursor_pos = r_o_pos;
    assign o_read_cell  = r_o_cell;
    assign o_scrolled   = r_o_scr;

    assign o_sts.will_scroll = ex_scroll;
    assign o_sts.is_clear    = (i_kind == KIND_CLEAR);
    assign o_sts.sweep_last  = sweep_last;
    assign o_sts.out_free    = out_free;

endmodule

### rtl/core/text_console_writer_unit.sv
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_dp.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | in        | i_valid / o_ready    | i_kind, i_char_code, i_read_index
//  out     | out       | o_valid / i_ready    | o_cursor_row/col/pos, o_read_cell,
//          |           |                      | o_scrolled
//  cfg     | in        | i_cfg_we (no wait)   | i_cfg_index, i_cfg_data
//
// A put, read or unused request that does not scroll does the cell write or
// read and the cursor update in the accept cycle, then loads the output once
// the output register is free. Clear and scroll sweep the cell store one
// entry a cycle through its single write port.
// After reset a clearing pass over the whole cell store runs with o_ready low.
// One request is in flight at a time; a stalled result holds the next one
// in its final cycle, while a finished result waiting in the output
// register does not block acceptance of the next request.
`timescale 1ns / 1ps

module text_console_writer_unit #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_read_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic [10:0] o_cursor_pos,
    output logic [15:0] o_read_cell,
    output logic        o_scrolled
);
    import tcw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tcw_dp #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cursor_pos (o_cursor_pos),
        .o_read_cell  (o_read_cell),
        .o_scrolled   (o_scrolled),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

### rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on text_console_writer_unit_defines.svh.
`timescale 1ns / 1ps
`include "text_console_writer_unit_defines.svh"

module tcw_checker #(
    parameter int ROWS = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_cursor_row,
    input logic [6:0]  o_cursor_col,
    input logic [10:0] o_cursor_pos,
    input logic [15:0] o_read_cell,
    input logic        o_scrolled
);

    `TCW_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_cursor_row) && $stable(o_cursor_col) && $stable(o_cursor_pos) && $stable(o_read_cell) && $stable(o_scrolled), "result changed while stalled")

    // Only one request is worked on at a time.
    `TCW_ASSERT_NEXT(a_one_in_flight, i_valid && o_ready, !o_ready, "request taken while busy")

    // A scroll always leaves the cursor at the start of the bottom row.
    `TCW_ASSERT_NOW(a_scroll_home, o_valid && o_scrolled, (o_cursor_row == 5'(ROWS - 1)) && (o_cursor_col == 7'd0), "scroll left cursor off bottom row start")

    // Loading a result finishes the request, so input opens at once.
    `TCW_ASSERT_NOW(a_result_frees_input, $rose(o_valid), o_ready, "result shown while still busy")

endmodule

bind text_console_writer_unit tcw_checker #(.ROWS(ROWS)) u_tcw_checker (.*);

### test/text_console_writer_checker.sv
// Checker for the text console writer: tracks the cell store, cursor and colours,
// and compares every result against its predicted value.
// Depends on tcw_pkg; instantiated beside the block by text_console_writer_unit_test.
`timescale 1ns / 1ps

module text_console_writer_checker #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_read_index,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [4:0]  o_cursor_row,
    input  logic [6:0]  o_cursor_col,
    input  logic [10:0] o_cursor_pos,
    input  logic [15:0] o_read_cell,
    input  logic        o_scrolled,
    output int          o_errors,
    output int          o_pending
);

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [10:0] pos;
        logic [15:0] glyph;
        logic        scrolled;
    } console_result_t;

    logic [15:0]     glyph_store [CELLS];
    int              cur_row;
    int              cur_col;
    logic [3:0]      fg_nib;
    logic [3:0]      bg_nib;
    console_result_t expected_results [$];
    int              mismatch_count = 0;

    function automatic logic [15:0] tinted(input logic [7:0] ch);
        return {bg_nib, fg_nib, ch};
    endfunction

    function automatic void fill_store(input logic [15:0] value);
        for (int i = 0; i < CELLS; i++) glyph_store[i] = value;
    endfunction

    // Step down one row; at the bottom, shift the screen up and blank the last row.
    function automatic bit advance_row();
        cur_row++;
        if (cur_row < ROWS) return 1'b0;
        for (int i = 0; i + COLUMNS < CELLS; i++) glyph_store[i] = glyph_store[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) glyph_store[i] = tinted(CH_SPACE);
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic console_result_t predict_console(input logic [1:0] kind,
                                                        input logic [7:0] ch,
                                                        input logic [10:0] idx);
        console_result_t r;
        bit              wrapped;
        int              at;
        r = '0;
        wrapped = 1'b0;
        case (kind)
            KIND_PUT: begin
                if (ch == CH_NEWLINE) begin
                    cur_col = 0;
                    wrapped = advance_row();
                end else if (ch == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                    end else if (cur_row > 0) begin
                        cur_row--;
                        cur_col = COLUMNS - 1;
                    end
                    glyph_store[cur_row * COLUMNS + cur_col] = tinted(CH_SPACE);
                end else begin
                    glyph_store[cur_row * COLUMNS + cur_col] = tinted(ch);
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        wrapped = advance_row();
                    end
                end
            end
            KIND_CLEAR: begin
                fill_store(tinted(CH_SPACE));
                cur_row = 0;
                cur_col = 0;
            end
            KIND_READ: begin
                if (idx < CELLS) r.glyph = glyph_store[idx];
            end
            default: ;
        endcase
        at = cur_row * COLUMNS + cur_col;
        r.row = cur_row[4:0];
        r.col = cur_col[6:0];
        r.pos = at[10:0];
        r.scrolled = wrapped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic compare_result();
        console_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unrequested result", 1, 0);
        end else begin
            want = expected_results.pop_front();
            if (o_cursor_row !== want.row)
                report_mismatch("cursor_row", int'(o_cursor_row), int'(want.row));
            if (o_cursor_col !== want.col)
                report_mismatch("cursor_col", int'(o_cursor_col), int'(want.col));
            if (o_cursor_pos !== want.pos)
                report_mismatch("cursor_pos", int'(o_cursor_pos), int'(want.pos));
            if (o_read_cell !== want.glyph)
                report_mismatch("read_cell", int'(o_read_cell), int'(want.glyph));
            if (o_scrolled !== want.scrolled)
                report_mismatch("scrolled", int'(o_scrolled), int'(want.scrolled));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fg_nib = RESET_FG;
            bg_nib = RESET_BG;
            fill_store(tinted(CH_SPACE));
            cur_row = 0;
            cur_col = 0;
        end else begin
            if (i_valid && o_ready)
                expected_results.push_back(predict_console(i_kind, i_char_code, i_read_index));
            if (o_valid && i_ready) compare_result();
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FG) fg_nib = i_cfg_data;
                else bg_nib = i_cfg_data;
            end
        end
        o_pending = expected_results.size();
        o_errors = mismatch_count;
    end

endmodule

### test/text_console_writer_unit_test.sv
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
// Depends on tcw_pkg, text_console_writer_unit and text_console_writer_checker.
`timescale 1ns / 1ps

module text_console_writer_unit_test;

    import tcw_pkg::*;

    localparam int ROWS       = 25;
    localparam int COLUMNS    = 80;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int STUCK_MAX  = 20000;
    localparam int PHASE_SIZE = 135;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [3:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_kind;
    logic [7:0]  i_char_code;
    logic [10:0] i_read_index;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_col;
    logic [10:0] o_cursor_pos;
    logic [15:0] o_read_cell;
    logic        o_scrolled;

    int mismatches;
    int in_flight;
    int items_sent = 0;
    int hold_left = 0;
    int stuck_cycles = 0;
    bit quiet_run = 1'b0;

    text_console_writer_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cursor_pos (o_cursor_pos),
        .o_read_cell  (o_read_cell),
        .o_scrolled   (o_scrolled)
    );

    text_console_writer_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cursor_pos (o_cursor_pos),
        .o_read_cell  (o_read_cell),
        .o_scrolled   (o_scrolled),
        .o_errors     (mismatches),
        .o_pending    (in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: stall in random bursts until the quiet stretch.
    always @(negedge i_clk) begin
        if (quiet_run) begin
            i_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            hold_left <= $urandom_range(0, 8);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [1:0] kind, input logic [7:0] ch,
                                input logic [10:0] idx);
        int gap;
        if (!quiet_run && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_char_code <= ch;
        i_read_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic write_colours(input logic [3:0] fg, input logic [3:0] bg);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_FG;
        i_cfg_data <= fg;
        @(negedge i_clk);
        i_cfg_index <= CFG_BG;
        i_cfg_data <= bg;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (in_flight != 0) @(negedge i_clk);
    endtask

    // Half near the start of a row, where short lines leave text; the rest anywhere in the store or past its end.
    function automatic logic [10:0] read_target();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return 11'($urandom_range(0, ROWS - 1) * COLUMNS + $urandom_range(0, 15));
        if (pick < 9) return 11'($urandom_range(0, CELLS - 1));
        return 11'($urandom_range(CELLS, 2047));
    endfunction

    task automatic run_random_phase(input int budget);
        int stop_at;
        int pick;
        int n;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                // a line of text, now and then long enough to wrap
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 8);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 11) == 0)
                        send_request(KIND_PUT, CH_BACKSPACE, 11'($urandom_range(0, 2047)));
                    else
                        send_request(KIND_PUT, 8'($urandom_range(0, 255)),
                                     11'($urandom_range(0, 2047)));
                end
                if ($urandom_range(0, 6) != 0)
                    send_request(KIND_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
            end else if (pick < 84) begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    send_request(KIND_READ, 8'($urandom_range(0, 255)), read_target());
            end else if (pick < 88) begin
                // run of blank lines to push the cursor off the bottom
                n = $urandom_range(5, 30);
                for (int k = 0; k < n; k++)
                    send_request(KIND_PUT, CH_NEWLINE, 11'($urandom_range(0, 2047)));
            end else if (pick < 92) begin
                send_request(KIND_SPARE, 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
            end else if (pick < 95) begin
                send_request(KIND_CLEAR, 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
            end else begin
                send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_FG;
        i_cfg_data = 4'h0;
        i_valid = 1'b0;
        i_kind = KIND_PUT;
        i_char_code = 8'h00;
        i_read_index = 11'd0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the clearing pass
        while (!o_ready) @(negedge i_clk);

        write_colours(4'hA, 4'h5);
        send_request(KIND_PUT, 8'h00, 11'd0);
        send_request(KIND_PUT, 8'hFF, 11'd2047);
        send_request(KIND_READ, 8'h00, 11'd0);
        send_request(KIND_READ, 8'h00, 11'd1);
        send_request(KIND_PUT, CH_BACKSPACE, 11'd0);
        send_request(KIND_PUT, CH_BACKSPACE, 11'd0);
        send_request(KIND_PUT, CH_BACKSPACE, 11'd0);
        send_request(KIND_READ, 8'hFF, 11'd0);
        send_request(KIND_PUT, CH_NEWLINE, 11'd0);
        // backspace from column 0 wraps to the end of the row above
        send_request(KIND_PUT, CH_BACKSPACE, 11'd0);
        send_request(KIND_PUT, 8'h41, 11'd0);
        send_request(KIND_READ, 8'h00, 11'(COLUMNS - 1));
        send_request(KIND_READ, 8'h00, 11'(CELLS - 1));
        send_request(KIND_READ, 8'h00, 11'(CELLS));
        send_request(KIND_READ, 8'h00, 11'd2047);
        send_request(KIND_SPARE, 8'hFF, 11'd2047);
        send_request(KIND_PUT, 8'h55, 11'h2AA);
        send_request(KIND_PUT, 8'hAA, 11'h555);
        send_request(KIND_CLEAR, 8'h00, 11'd0);
        send_request(KIND_READ, 8'h00, 11'd1);
        send_request(KIND_READ, 8'h00, 11'(COLUMNS));
        drain_results();

        write_colours(4'h0, 4'h0);
        run_random_phase(PHASE_SIZE);
        drain_results();
        write_colours(4'hF, 4'hF);
        run_random_phase(PHASE_SIZE);
        drain_results();
        write_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        run_random_phase(PHASE_SIZE);
        drain_results();
        write_colours(RESET_FG, RESET_BG);
        quiet_run = 1'b1;
        run_random_phase(PHASE_SIZE);
        drain_results();

        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dp.sv
rtl/core/text_console_writer_unit.sv
rtl/core/tcw_checker.sv
test/text_console_writer_checker.sv
test/text_console_writer_unit_test.sv
